/* rtl/qts_pkg.sv */
`timescale 1ns / 1ps

package qts_pkg;

    localparam int CHAR_W = 16;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;
    localparam int IDX_W  = 3;

    localparam logic [CHAR_W-1:0] WS_LIMIT = 16'h0020;
    localparam logic [CHAR_W-1:0] LF_CODE  = 16'h000A;
    localparam logic [CHAR_W-1:0] NUL_CODE = 16'h0000;

    typedef enum logic [IDX_W-1:0] {
        REG_SEPARATOR = 3'd0,
        REG_QUOTE     = 3'd1,
        REG_COMMENT   = 3'd2,
        REG_OPEN      = 3'd3,
        REG_CLOSE     = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_TEXT    = 5'b00100,
        MODE_COMMENT = 5'b01000,
        MODE_STOP    = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [3:0][CHAR_W-1:0] separator_set;
        logic [1:0][CHAR_W-1:0] quote_set;
        logic [CHAR_W-1:0]      comment_char;
        logic [CHAR_W-1:0]      open_mark;
        logic [CHAR_W-1:0]      close_mark;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              char_valid;
        logic              token_done;
        logic              token_quoted;
        logic              run_last;
    } rec_t;

    typedef struct packed {
        mode_t      mode_next;
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } step_t;

    function automatic rec_t mk_char(input logic [CHAR_W-1:0] c);
        rec_t r;
        r              = '0;
        r.char_out     = c;
        r.char_valid   = 1'b1;
        return r;
    endfunction

    function automatic rec_t mk_done(input logic quoted);
        rec_t r;
        r              = '0;
        r.token_done   = 1'b1;
        r.token_quoted = quoted;
        return r;
    endfunction

endpackage

/* rtl/qts_char_if.sv */
`timescale 1ns / 1ps

interface qts_char_if;
    import qts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

/* rtl/qts_tok_if.sv */
`timescale 1ns / 1ps

interface qts_tok_if;
    import qts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              token_done;
    logic              token_quoted;
    logic              run_last;

    modport source (
        output valid, output char_out, output char_valid, output token_done,
        output token_quoted, output run_last, input ready
    );
    modport sink (
        input valid, input char_out, input char_valid, input token_done,
        input token_quoted, input run_last, output ready
    );
endinterface

/* rtl/qts_cfg_regs.sv */
`timescale 1ns / 1ps

module qts_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qts_pkg::ADDR_W-1:0] paddr,
    input  logic [qts_pkg::DATA_W-1:0] pwdata,
    output logic [qts_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output qts_pkg::cfg_t              cfg
);
    import qts_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-IDX_W]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SEPARATOR: cfg_next.separator_set = pwdata;
                REG_QUOTE:     cfg_next.quote_set     = pwdata[2*CHAR_W-1:0];
                REG_COMMENT:   cfg_next.comment_char  = pwdata[CHAR_W-1:0];
                REG_OPEN:      cfg_next.open_mark     = pwdata[CHAR_W-1:0];
                REG_CLOSE:     cfg_next.close_mark    = pwdata[CHAR_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SEPARATOR: prdata = cfg_reg.separator_set;
            REG_QUOTE:     prdata = DATA_W'(cfg_reg.quote_set);
            REG_COMMENT:   prdata = DATA_W'(cfg_reg.comment_char);
            REG_OPEN:      prdata = DATA_W'(cfg_reg.open_mark);
            REG_CLOSE:     prdata = DATA_W'(cfg_reg.close_mark);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator_set <= 64'd44;
            cfg_reg.quote_set     <= 32'd34;
            cfg_reg.comment_char  <= 16'd35;
            cfg_reg.open_mark     <= 16'd60;
            cfg_reg.close_mark    <= 16'd62;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/qts_step.sv */
`timescale 1ns / 1ps

module qts_step (
    input  qts_pkg::mode_t             mode,
    input  logic [qts_pkg::CHAR_W-1:0] c,
    input  logic                       last,
    input  qts_pkg::cfg_t              cfg,
    output qts_pkg::step_t             res
);
    import qts_pkg::*;

    logic  is_nul;
    logic  is_blank;
    logic  is_quote;
    logic  is_comment;
    logic  is_open;
    logic  is_close;
    logic  sep_hit;
    logic  close_q;
    step_t s;

    always_comb
    begin
        sep_hit = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (cfg.separator_set[i] != NUL_CODE && cfg.separator_set[i] == c)
            begin
                sep_hit = 1'b1;
            end
        end
    end

    assign is_nul     = (c == NUL_CODE);
    assign is_blank   = (c <= WS_LIMIT) || sep_hit;
    assign is_quote   = (cfg.quote_set[0] != NUL_CODE && cfg.quote_set[0] == c)
                     || (cfg.quote_set[1] != NUL_CODE && cfg.quote_set[1] == c);
    assign is_comment = (cfg.comment_char != NUL_CODE) && (c == cfg.comment_char);
    assign is_open    = (c == cfg.open_mark);
    assign is_close   = (c == cfg.close_mark);

    always_comb
    begin
        s.mode_next = mode;
        s.count     = 2'd0;
        s.rec0      = '0;
        s.rec1      = '0;
        close_q     = 1'b0;

        case (mode)
            MODE_WORD:
            begin
                s.count = 2'd1;
                if (is_nul)
                begin
                    s.rec0      = mk_done(1'b0);
                    s.mode_next = MODE_STOP;
                end
                else if (is_blank)
                begin
                    s.rec0      = mk_done(1'b0);
                    s.mode_next = MODE_IDLE;
                end
                else if (is_open)
                begin
                    // The mark closes the word and starts the next one.
                    s.rec0  = mk_done(1'b0);
                    s.rec1  = mk_char(c);
                    s.count = 2'd2;
                end
                else if (is_close)
                begin
                    s.rec0            = mk_char(c);
                    s.rec0.token_done = 1'b1;
                    s.mode_next       = MODE_IDLE;
                end
                else if (is_comment)
                begin
                    s.rec0      = mk_done(1'b0);
                    s.mode_next = MODE_COMMENT;
                end
                else if (is_quote)
                begin
                    s.rec0      = mk_done(1'b0);
                    s.mode_next = MODE_TEXT;
                end
                else
                begin
                    s.rec0 = mk_char(c);
                end
            end
            MODE_TEXT:
            begin
                s.count = 2'd1;
                if (is_nul)
                begin
                    s.rec0      = mk_done(1'b1);
                    s.mode_next = MODE_STOP;
                end
                else if (is_quote)
                begin
                    s.rec0      = mk_done(1'b1);
                    s.mode_next = MODE_IDLE;
                end
                else if (is_comment)
                begin
                    s.rec0      = mk_done(1'b1);
                    s.mode_next = MODE_COMMENT;
                end
                else
                begin
                    s.rec0 = mk_char(c);
                end
            end
            MODE_COMMENT:
            begin
                if (is_nul)
                begin
                    s.mode_next = MODE_STOP;
                end
                else if (c == LF_CODE)
                begin
                    s.mode_next = MODE_IDLE;
                end
            end
            MODE_STOP:
            begin
                s.mode_next = MODE_STOP;
            end
            default:
            begin
                if (is_nul)
                begin
                    s.mode_next = MODE_STOP;
                end
                else if (is_blank)
                begin
                    s.mode_next = MODE_IDLE;
                end
                else if (is_quote)
                begin
                    s.mode_next = MODE_TEXT;
                end
                else if (is_comment)
                begin
                    s.mode_next = MODE_COMMENT;
                end
                else
                begin
                    s.rec0      = mk_char(c);
                    s.count     = 2'd1;
                    s.mode_next = MODE_WORD;
                end
            end
        endcase

        // On the last item an open token is closed, folded into a pending
        // character record when there is one, and the scan returns to idle.
        if (last)
        begin
            if (s.mode_next == MODE_WORD || s.mode_next == MODE_TEXT)
            begin
                close_q = (s.mode_next == MODE_TEXT);
                if (s.count == 2'd0)
                begin
                    s.rec0  = mk_done(close_q);
                    s.count = 2'd1;
                end
                else if (s.count == 2'd1)
                begin
                    if (s.rec0.char_valid && !s.rec0.token_done)
                    begin
                        s.rec0.token_done   = 1'b1;
                        s.rec0.token_quoted = close_q;
                    end
                    else
                    begin
                        s.rec1  = mk_done(close_q);
                        s.count = 2'd2;
                    end
                end
                else if (s.rec1.char_valid && !s.rec1.token_done)
                begin
                    s.rec1.token_done   = 1'b1;
                    s.rec1.token_quoted = close_q;
                end
            end
            s.mode_next = MODE_IDLE;
        end

        if (s.count == 2'd1)
        begin
            s.rec0.run_last = 1'b1;
        end
        else if (s.count == 2'd2)
        begin
            s.rec1.run_last = 1'b1;
        end
    end

    assign res = s;

endmodule

/* rtl/qts_out_fifo.sv */
`timescale 1ns / 1ps

module qts_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  qts_pkg::rec_t push_rec0,
    input  qts_pkg::rec_t push_rec1,
    input  logic          pop,
    output qts_pkg::rec_t head,
    output logic          head_valid,
    output logic          room2
);
    import qts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1))
        begin
            q = '0;
        end
        else
        begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    assign rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    assign count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign room2      = (count_reg <= CNT_W'(DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_rec0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push_rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/quoted_token_scanner_core.sv */
`timescale 1ns / 1ps

// Token scanner for a stream of 16-bit characters.
// in_ch carries one character request per handshake (char_in, end_of_text).
// out_ch carries token records: a character appended to the current token,
// a token close (token_done, token_quoted), or both; run_last marks the last
// record caused by a character. A character causes zero, one or two records.
// Separators, quote characters, comment character and the open and close
// marks are set through the APB port; the user must write them only while no
// character is in flight, which the block does not enforce. A record is
// offered once its character has passed the input register and the result
// queue. Throughput: one character per cycle; the input register feeds one
// pass of compare logic that writes a small result queue, and a character is
// processed only when the queue has room for two records. The output side
// moves one record per cycle while the receiver is ready. When the receiver
// stalls, the queue fills and in_ch.ready drops once the input register holds
// a character that cannot be processed. Reset returns the configuration to
// its defaults, empties the queue and puts the scanner idle between tokens.
module quoted_token_scanner_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qts_pkg::ADDR_W-1:0] paddr,
    input  logic [qts_pkg::DATA_W-1:0] pwdata,
    output logic [qts_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    qts_char_if.sink                   in_ch,
    qts_tok_if.source                  out_ch
);
    import qts_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    mode_t             mode_reg;
    mode_t             mode_next;
    step_t             step;
    logic              room2;
    logic              process;
    logic              in_take;
    logic [1:0]        push_count;
    rec_t              head;
    logic              head_valid;

    qts_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qts_step u_step (
        .mode (mode_reg),
        .c    (in_char_reg),
        .last (in_last_reg),
        .cfg  (cfg),
        .res  (step)
    );

    assign process       = in_valid_reg && room2;
    assign in_ch.ready   = !in_valid_reg || process;
    assign in_take       = in_ch.valid && in_ch.ready;
    assign in_valid_next = in_take || (in_valid_reg && !process);
    assign mode_next     = process ? step.mode_next : mode_reg;
    assign push_count    = process ? step.count : 2'd0;

    qts_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_rec0  (step.rec0),
        .push_rec1  (step.rec1),
        .pop        (out_ch.valid && out_ch.ready),
        .head       (head),
        .head_valid (head_valid),
        .room2      (room2)
    );

    assign out_ch.valid        = head_valid;
    assign out_ch.char_out     = head.char_out;
    assign out_ch.char_valid   = head.char_valid;
    assign out_ch.token_done   = head.token_done;
    assign out_ch.token_quoted = head.token_quoted;
    assign out_ch.run_last     = head.run_last;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= in_ch.char_in;
            in_last_reg <= in_ch.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
        end
    end

endmodule

/* rtl/qts_checker.sv */
`timescale 1ns / 1ps

module qts_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [qts_pkg::CHAR_W-1:0] char_out,
    input logic                       char_valid,
    input logic                       token_done,
    input logic                       token_quoted,
    input logic                       run_last
);
    import qts_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(char_out) && $stable(char_valid)
            && $stable(token_done) && $stable(token_quoted) && $stable(run_last))
        else $error("result changed while stalled");

    a_rec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_valid || token_done)
        else $error("empty result record");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> char_out == '0)
        else $error("character set without char_valid");

    a_quoted_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_quoted |-> token_done)
        else $error("token_quoted without token_done");

endmodule

bind quoted_token_scanner_core qts_checker u_qts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .char_out     (out_ch.char_out),
    .char_valid   (out_ch.char_valid),
    .token_done   (out_ch.token_done),
    .token_quoted (out_ch.token_quoted),
    .run_last     (out_ch.run_last)
);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import qts_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 280;
    localparam int FLOOD_ITEMS   = 40;
    localparam int HOLD_CYCLES   = 150;

    localparam logic [15:0] CH_SP    = 16'h0020;
    localparam logic [15:0] CH_DQ    = 16'h0022;
    localparam logic [15:0] CH_HASH  = 16'h0023;
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_LT    = 16'h003C;
    localparam logic [15:0] CH_GT    = 16'h003E;

    typedef struct packed {
        logic [1:0] n;
        rec_t       r0;
        rec_t       r1;
    } rec_pair_t;

    typedef struct packed {
        logic [15:0] ch;
        logic        eot;
        logic        typed;
        rec_pair_t   want;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    qts_char_if char_bus ();
    qts_tok_if  tok_bus ();

    quoted_token_scanner_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (char_bus),
        .out_ch  (tok_bus)
    );

    // Scanner state and configuration as the testbench believes them to be.
    mode_t       scan_state;
    logic [63:0] sep_cfg;
    logic [31:0] quote_cfg;
    logic [15:0] comment_cfg;
    logic [15:0] open_cfg;
    logic [15:0] close_cfg;

    rec_t pending_recs[$];
    int   mismatches = 0;
    int   hold_token = 0;
    int   burst_left = 0;
    bit   gaps_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic rec_t rec(logic [15:0] c, logic [3:0] flags);
        rec_t r;
        r.char_out = c;
        {r.char_valid, r.token_done, r.token_quoted, r.run_last} = flags;
        return r;
    endfunction

    function automatic rec_pair_t just_one(rec_t r);
        rec_pair_t p;
        p = '0;
        p.n = 2'd1;
        p.r0 = r;
        return p;
    endfunction

    function automatic logic is_sep(logic [15:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (sep_cfg[16*i +: 16] != 16'h0000 && sep_cfg[16*i +: 16] == c)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic is_quote(logic [15:0] c);
        return (quote_cfg[15:0] != 16'h0000 && quote_cfg[15:0] == c)
            || (quote_cfg[31:16] != 16'h0000 && quote_cfg[31:16] == c);
    endfunction

    function automatic logic is_comment(logic [15:0] c);
        return comment_cfg != 16'h0000 && c == comment_cfg;
    endfunction

    function automatic rec_pair_t add_char(rec_pair_t p, logic [15:0] c);
        if (p.n == 2'd0)
            p.r0 = rec(c, 4'b1000);
        else
            p.r1 = rec(c, 4'b1000);
        p.n = p.n + 2'd1;
        return p;
    endfunction

    // A close folds into a character record of the same request that has not
    // been closed yet; otherwise it becomes a record of its own.
    function automatic rec_pair_t close_token(rec_pair_t p, logic quoted);
        if (p.n == 2'd1 && p.r0.char_valid && !p.r0.token_done)
        begin
            p.r0.token_done = 1'b1;
            p.r0.token_quoted = quoted;
        end
        else if (p.n == 2'd2 && p.r1.char_valid && !p.r1.token_done)
        begin
            p.r1.token_done = 1'b1;
            p.r1.token_quoted = quoted;
        end
        else if (p.n == 2'd0)
        begin
            p.r0 = rec(16'h0000, {2'b01, quoted, 1'b0});
            p.n = 2'd1;
        end
        else
        begin
            p.r1 = rec(16'h0000, {2'b01, quoted, 1'b0});
            p.n = 2'd2;
        end
        return p;
    endfunction

    function automatic rec_pair_t scan_char(logic [15:0] c, logic eot);
        rec_pair_t p;
        logic blank;
        p = '0;
        blank = (c <= WS_LIMIT) || is_sep(c);
        case (scan_state)
            MODE_WORD:
            begin
                if (c == NUL_CODE)
                begin
                    p = close_token(p, 1'b0);
                    scan_state = MODE_STOP;
                end
                else if (blank)
                begin
                    p = close_token(p, 1'b0);
                    scan_state = MODE_IDLE;
                end
                else if (c == open_cfg)
                begin
                    p = close_token(p, 1'b0);
                    p = add_char(p, c);
                end
                else if (c == close_cfg)
                begin
                    p = add_char(p, c);
                    p = close_token(p, 1'b0);
                    scan_state = MODE_IDLE;
                end
                else if (is_comment(c))
                begin
                    p = close_token(p, 1'b0);
                    scan_state = MODE_COMMENT;
                end
                else if (is_quote(c))
                begin
                    p = close_token(p, 1'b0);
                    scan_state = MODE_TEXT;
                end
                else
                    p = add_char(p, c);
            end
            MODE_TEXT:
            begin
                if (c == NUL_CODE)
                begin
                    p = close_token(p, 1'b1);
                    scan_state = MODE_STOP;
                end
                else if (is_quote(c))
                begin
                    p = close_token(p, 1'b1);
                    scan_state = MODE_IDLE;
                end
                else if (is_comment(c))
                begin
                    p = close_token(p, 1'b1);
                    scan_state = MODE_COMMENT;
                end
                else
                    p = add_char(p, c);
            end
            MODE_COMMENT:
            begin
                if (c == NUL_CODE)
                    scan_state = MODE_STOP;
                else if (c == LF_CODE)
                    scan_state = MODE_IDLE;
            end
            MODE_STOP:
            begin
            end
            default:
            begin
                if (c == NUL_CODE)
                    scan_state = MODE_STOP;
                else if (blank)
                    scan_state = MODE_IDLE;
                else if (is_quote(c))
                    scan_state = MODE_TEXT;
                else if (is_comment(c))
                    scan_state = MODE_COMMENT;
                else
                begin
                    p = add_char(p, c);
                    scan_state = MODE_WORD;
                end
            end
        endcase

        // The end of a buffer flushes whatever token is still open.
        if (eot)
        begin
            if (scan_state == MODE_WORD)
                p = close_token(p, 1'b0);
            else if (scan_state == MODE_TEXT)
                p = close_token(p, 1'b1);
            scan_state = MODE_IDLE;
        end

        if (p.n == 2'd1)
            p.r0.run_last = 1'b1;
        else if (p.n == 2'd2)
            p.r1.run_last = 1'b1;
        return p;
    endfunction

    function automatic logic [15:0] pick_char();
        int k;
        int slot;
        logic [15:0] c;
        k = $urandom_range(0, 99);
        slot = $urandom_range(0, 3);
        if (k < 35)
            c = 16'h0061 + 16'($urandom_range(0, 25));
        else if (k < 45)
            c = 16'($urandom_range(16'h0021, 16'hFFFF));
        else if (k < 50)
            c = CH_SP;
        else if (k < 53)
            c = LF_CODE;
        else if (k < 55)
            c = 16'($urandom_range(1, 16'h0020));
        else if (k < 63)
            c = sep_cfg[16*slot +: 16];
        else if (k < 71)
            c = quote_cfg[16*(slot % 2) +: 16];
        else if (k < 76)
            c = comment_cfg;
        else if (k < 81)
            c = open_cfg;
        else if (k < 86)
            c = close_cfg;
        else if (k < 88)
            c = NUL_CODE;
        else
            c = 16'($urandom());
        // An unused configuration slot reads as zero; keep NUL rare.
        if (k >= 55 && k < 86 && c == NUL_CODE)
            c = CH_SP;
        return c;
    endfunction

    function automatic row_t random_row();
        row_t r;
        r = '0;
        r.ch = pick_char();
        if (scan_state == MODE_STOP)
            r.eot = ($urandom_range(0, 3) == 0);
        else
            r.eot = ($urandom_range(0, 32) == 0);
        return r;
    endfunction

    function automatic logic [15:0] rand_cfg_char();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'h0000;
        else if (k == 1)
            return 16'($urandom());
        return 16'($urandom_range(16'h0021, 16'h007E));
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    // A character request is taken at the edge where valid and ready are both high.
    task automatic send_row(row_t r);
        rec_pair_t got;
        char_bus.valid <= 1'b1;
        char_bus.char_in <= r.ch;
        char_bus.end_of_text <= r.eot;
        do @(posedge clk); while (!char_bus.ready);
        got = scan_char(r.ch, r.eot);
        if (r.typed)
            got = r.want;
        if (got.n > 2'd0)
            pending_recs.insert(pending_recs.size(), got.r0);
        if (got.n > 2'd1)
            pending_recs.insert(pending_recs.size(), got.r1);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gaps_on && gap > 0)
            begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        char_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_recs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_SEPARATOR: sep_cfg = v;
            REG_QUOTE:     quote_cfg = v[31:0];
            REG_COMMENT:   comment_cfg = v[15:0];
            REG_OPEN:      open_cfg = v[15:0];
            REG_CLOSE:     close_cfg = v[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(logic [63:0] seps, logic [31:0] quotes, logic [15:0] comment,
                             logic [15:0] open_ch, logic [15:0] close_ch);
        write_reg(REG_SEPARATOR, seps);
        write_reg(REG_QUOTE, {32'h0, quotes});
        write_reg(REG_COMMENT, {48'h0, comment});
        write_reg(REG_OPEN, {48'h0, open_ch});
        write_reg(REG_CLOSE, {48'h0, close_ch});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : token_sink
        int style;
        int style_left;
        int hold_left;
        int hold_seen;
        rec_t want;
        logic nr;
        style = 0;
        style_left = 0;
        hold_left = 0;
        hold_seen = 0;
        tok_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tok_bus.valid && tok_bus.ready)
            begin
                if (pending_recs.size() == 0)
                begin
                    $error("record with no character behind it: char_out %h", tok_bus.char_out);
                    mismatches++;
                end
                else
                begin
                    want = pending_recs[0];
                    pending_recs.delete(0);
                    check_field("char_out", want.char_out, tok_bus.char_out);
                    check_field("char_valid", 16'(want.char_valid), 16'(tok_bus.char_valid));
                    check_field("token_done", 16'(want.token_done), 16'(tok_bus.token_done));
                    check_field("token_quoted", 16'(want.token_quoted),
                                16'(tok_bus.token_quoted));
                    check_field("run_last", 16'(want.run_last), 16'(tok_bus.run_last));
                end
            end

            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (style_left == 0)
            begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            case (style)
                0:       nr = 1'b1;
                1:       nr = 1'($urandom_range(0, 1));
                2:       nr = ($urandom_range(0, 3) != 0);
                default: nr = style_left[2];
            endcase
            if (hold_left > 0)
            begin
                nr = 1'b0;
                hold_left--;
            end
            tok_bus.ready <= nr;
        end
    end

    initial
    begin : watchdog
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        row_t dir_rows[$];
        rst_n = 1'b0;
        char_bus.valid = 1'b0;
        char_bus.char_in = 16'h0000;
        char_bus.end_of_text = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sep_cfg = {48'h0, CH_COMMA};
        quote_cfg = {16'h0, CH_DQ};
        comment_cfg = CH_HASH;
        open_cfg = CH_LT;
        close_cfg = CH_GT;
        scan_state = MODE_IDLE;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Default configuration: comma separates, double quote, hash comment, < and >.
        dir_rows = '{
            '{ch: 16'h0061, eot: 1'b0, typed: 1'b1, want: just_one(rec(16'h0061, 4'b1001))},
            '{ch: 16'hFFFF, eot: 1'b0, typed: 1'b1, want: just_one(rec(16'hFFFF, 4'b1001))},
            '{ch: CH_SP,    eot: 1'b0, typed: 1'b1, want: just_one(rec(16'h0000, 4'b0101))},
            '{ch: 16'h0021, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_COMMA, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_LT,    eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: 16'h0062, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_LT,    eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_GT,    eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_GT,    eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_DQ,    eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_HASH,  eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: 16'h0079, eot: 1'b0, typed: 1'b1, want: '0},
            '{ch: LF_CODE,  eot: 1'b0, typed: 1'b1, want: '0},
            '{ch: CH_DQ,    eot: 1'b0, typed: 1'b1, want: '0},
            '{ch: 16'h0071, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_DQ,    eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_DQ,    eot: 1'b0, typed: 1'b1, want: '0},
            '{ch: NUL_CODE, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: 16'h007A, eot: 1'b1, typed: 1'b1, want: '0},
            '{ch: 16'h006D, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: NUL_CODE, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_DQ,    eot: 1'b1, typed: 1'b1, want: '0},
            '{ch: 16'h0061, eot: 1'b1, typed: 1'b1, want: just_one(rec(16'h0061, 4'b1101))},
            '{ch: CH_DQ,    eot: 1'b0, typed: 1'b1, want: '0},
            '{ch: 16'h0076, eot: 1'b1, typed: 1'b0, want: '0},
            '{ch: 16'h0063, eot: 1'b0, typed: 1'b0, want: '0},
            '{ch: CH_LT,    eot: 1'b1, typed: 1'b0, want: '0}
        };
        foreach (dir_rows[i])
        begin
            send_row(dir_rows[i]);
            pace();
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                case (ph)
                    1: configure(64'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000);
                    2: configure({64{1'b1}}, {32{1'b1}}, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    6: configure({48'h0, CH_COMMA}, {16'h0, CH_DQ}, CH_HASH, CH_LT, CH_GT);
                    default:
                        configure({rand_cfg_char(), rand_cfg_char(), rand_cfg_char(),
                                   rand_cfg_char()},
                                  {rand_cfg_char(), rand_cfg_char()},
                                  rand_cfg_char(), rand_cfg_char(), rand_cfg_char());
                endcase
            end
            gaps_on = (ph != 4);
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                if ((ph == 2 || ph == 5) && i == RANDOM_ITEMS / 2)
                begin
                    // The sink holds off while requests keep coming, then the
                    // source waits for every pending record before going on.
                    hold_token++;
                    repeat (FLOOD_ITEMS) send_row(random_row());
                    char_bus.valid <= 1'b0;
                    do @(posedge clk); while (pending_recs.size() != 0);
                end
                send_row(random_row());
                pace();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
